// ===== hdl/dvr_pkg.sv =====
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared widths, divisor constants and the command and status types of the
// bit-serial multiply and divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dvr_pkg;

   localparam int MCAND_W  = 16;
   localparam int MPLIER_W = 21;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int REM_W    = 20;
   localparam int QUO_W    = 17;
   localparam int CNT_W    = $clog2(PROD_W);

   localparam logic [REM_W:0] DIV_VOLT = 21'd30000;
   localparam logic [REM_W:0] DIV_PPM  = 21'd1000000;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
      logic                div_ppm;
   } md_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } md_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/dvr_muldiv.sv =====
// ----------------------------------------------------------------------------
// dvr_muldiv
// Bit-serial multiply followed by restoring division by one of two fixed constants.
// One multiplicand bit per cycle, then one product bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_muldiv (
   input  wire                clock,
   input  wire                reset,
   input  dvr_pkg::md_cmd_type cmd,
   output dvr_pkg::md_rsp_type rsp
);

   localparam logic [1:0] MD_IDLE = 2'd0;
   localparam logic [1:0] MD_MUL  = 2'd1;
   localparam logic [1:0] MD_DIV  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic                          done_ff, done_in;
   logic [dvr_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [dvr_pkg::MCAND_W-1:0]   a_ff, a_in;
   logic [dvr_pkg::MPLIER_W-1:0]  b_ff, b_in;
   logic                          sel_ff, sel_in;
   logic [dvr_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [dvr_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [dvr_pkg::QUO_W-1:0]     quo_ff, quo_in;

   logic [dvr_pkg::REM_W:0]       trial;
   logic [dvr_pkg::REM_W:0]       divisor;
   logic [dvr_pkg::REM_W:0]       trial_sub;
   logic                          qbit;

   always_comb begin
      divisor   = sel_ff ? dvr_pkg::DIV_PPM : dvr_pkg::DIV_VOLT;
      trial     = {rem_ff, acc_ff[dvr_pkg::PROD_W-1]};
      trial_sub = trial - divisor;
      qbit      = (trial >= divisor);
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      sel_in   = sel_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.mcand;
               b_in     = cmd.mplier;
               sel_in   = cmd.div_ppm;
               acc_in   = '0;
               cnt_in   = dvr_pkg::CNT_W'(dvr_pkg::MCAND_W - 1);
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // MSB-first shift and add.
            acc_in = {acc_ff[dvr_pkg::PROD_W-2:0], 1'b0}
                     + (a_ff[dvr_pkg::MCAND_W-1]
                        ? {{dvr_pkg::MCAND_W{1'b0}}, b_ff}
                        : {dvr_pkg::PROD_W{1'b0}});
            a_in   = {a_ff[dvr_pkg::MCAND_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in   = dvr_pkg::CNT_W'(dvr_pkg::PROD_W - 1);
               rem_in   = '0;
               quo_in   = '0;
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DIV: begin
            // The remainder stays below the divisor, so it fits REM_W bits.
            rem_in = qbit ? trial_sub[dvr_pkg::REM_W-1:0] : trial[dvr_pkg::REM_W-1:0];
            quo_in = {quo_ff[dvr_pkg::QUO_W-2:0], qbit};
            acc_in = {acc_ff[dvr_pkg::PROD_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      sel_ff <= sel_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = (state_ff != MD_IDLE);
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/dac_voltage_regulation.sv =====
// ----------------------------------------------------------------------------
// dac_voltage_regulation
// Steps a DAC code toward a target voltage from settled voltage samples,
// with optional gain and offset calibration of each sample.
//
//   Channel  Direction  Handshake               Contents
//   req_*    in         req_valid / req_stall   action, target, tolerance,
//                                               timeout, raw sample
//   rsp_*    out        rsp_valid / rsp_stall   dac code, drive enable,
//                                               status, measured voltage
//   csr_*    in/out     APB style, pready high  calibration and DAC setup
//
// A rejected start goes straight to the output state. An accepted start takes
// one pass of the shared bit-serial unit (16 multiply plus 37 divide steps).
// A sample that needs a step takes one pass, or two with calibration, since
// calibration and the correction step each take one pass of that unit.
// Reset is synchronous and returns the registers and regulation state to
// their defaults. A stalled result sits in the output register while the
// next request is already taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_voltage_regulation (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_action,
   input  wire  [15:0] req_target_mv,
   input  wire  [15:0] req_tolerance_mv,
   input  wire  [15:0] req_timeout_ms,
   input  wire  [15:0] req_raw_mv,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [15:0] rsp_dac_code,
   output logic        rsp_drive_enable,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_measured_mv,

   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CODE = 3'd1;
   localparam logic [2:0] S_CAL  = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_PUT  = 3'd5;

   localparam logic [2:0] ST_ADJUSTING = 3'd0;
   localparam logic [2:0] ST_REACHED   = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_MANUAL    = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;
   localparam logic [2:0] ST_TIMEOUT   = 3'd5;
   localparam logic [2:0] ST_IGNORED   = 3'd6;

   localparam logic [4:0] ADDR_GAIN    = 5'd0;
   localparam logic [4:0] ADDR_OFFSET  = 5'd4;
   localparam logic [4:0] ADDR_CALV    = 5'd8;
   localparam logic [4:0] ADDR_PRESENT = 5'd12;
   localparam logic [4:0] ADDR_FS      = 5'd16;

   localparam logic [20:0] GAIN_RESET = 21'd1000000;
   localparam logic [20:0] GAIN_MIN   = 21'd500000;
   localparam logic [20:0] GAIN_MAX   = 21'd1500000;
   localparam logic [15:0] VOLT_MAX   = 16'd30000;
   localparam logic [16:0] SETTLE_MS  = 17'd5;

   // Configuration registers.
   logic [20:0] gain_ff, gain_in;
   logic [15:0] offset_ff, offset_in;
   logic        calv_ff, calv_in;
   logic        present_ff, present_in;
   logic [15:0] fs_ff, fs_in;

   // Regulation state.
   logic [15:0] code_ff, code_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [14:0] goal_ff, goal_in;
   logic [15:0] allowed_ff, allowed_in;
   logic [15:0] budget_ff, budget_in;
   logic        adjusting_ff, adjusting_in;
   logic        enabled_ff, enabled_in;

   // Request being worked on.
   logic [2:0]  state_ff, state_in;
   logic [15:0] tgt_ff, tgt_in;
   logic [15:0] tol_ff, tol_in;
   logic [15:0] tmo_ff, tmo_in;
   logic [15:0] meas_ff, meas_in;
   logic        neg_ff, neg_in;
   logic [2:0]  status_ff, status_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_code_ff, rsp_code_in;
   logic        rsp_en_ff, rsp_en_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_meas_ff, rsp_meas_in;

   dvr_pkg::md_cmd_type md_cmd;
   dvr_pkg::md_rsp_type md_rsp;

   logic        req_accept;
   logic        csr_write;
   logic        gain_ok;
   logic [17:0] cal_sum;
   logic [16:0] el_sum;
   logic [16:0] err;
   logic [16:0] err_abs;
   logic [16:0] step_mag;
   logic [17:0] next_sum;
   logic        next_bad;

   dvr_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .rsp   (md_rsp)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr)
         ADDR_GAIN:    csr_prdata = {11'd0, gain_ff};
         ADDR_OFFSET:  csr_prdata = {16'd0, offset_ff};
         ADDR_CALV:    csr_prdata = {31'd0, calv_ff};
         ADDR_PRESENT: csr_prdata = {31'd0, present_ff};
         ADDR_FS:      csr_prdata = {16'd0, fs_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      gain_in    = gain_ff;
      offset_in  = offset_ff;
      calv_in    = calv_ff;
      present_in = present_ff;
      fs_in      = fs_ff;
      if (csr_write) begin
         unique case (csr_paddr)
            ADDR_GAIN:    gain_in    = csr_pwdata[20:0];
            ADDR_OFFSET:  offset_in  = csr_pwdata[15:0];
            ADDR_CALV:    calv_in    = csr_pwdata[0];
            ADDR_PRESENT: present_in = csr_pwdata[0];
            ADDR_FS:      fs_in      = csr_pwdata[15:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      gain_ok  = calv_ff && (gain_ff >= GAIN_MIN) && (gain_ff <= GAIN_MAX);
      cal_sum  = $signed({1'b0, md_rsp.quotient}) + $signed({{2{offset_ff[15]}}, offset_ff});
      el_sum   = {1'b0, elapsed_ff} + SETTLE_MS;
      err      = {2'b00, goal_ff} - {1'b0, meas_ff};
      err_abs  = err[16] ? (17'd0 - err) : err;
      step_mag = (md_rsp.quotient == '0) ? 17'd1 : md_rsp.quotient;
      if (neg_ff) begin
         next_sum = {2'b00, code_ff} - {1'b0, step_mag};
         next_bad = next_sum[17];
      end else begin
         next_sum = {2'b00, code_ff} + {1'b0, step_mag};
         next_bad = (next_sum > {2'b00, fs_ff});
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      elapsed_in   = elapsed_ff;
      goal_in      = goal_ff;
      allowed_in   = allowed_ff;
      budget_in    = budget_ff;
      adjusting_in = adjusting_ff;
      enabled_in   = enabled_ff;
      tgt_in       = tgt_ff;
      tol_in       = tol_ff;
      tmo_in       = tmo_ff;
      meas_in      = meas_ff;
      neg_in       = neg_ff;
      status_in    = status_ff;
      md_cmd       = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_en_in     = rsp_en_ff;
      rsp_status_in = rsp_status_ff;
      rsp_meas_in   = rsp_meas_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               tgt_in = req_target_mv;
               tol_in = req_tolerance_mv;
               tmo_in = req_timeout_ms;
               if (!req_action) begin
                  meas_in = 16'd0;
                  priority if (req_target_mv == 16'd0 || req_target_mv > VOLT_MAX
                               || req_tolerance_mv == 16'd0) begin
                     status_in = ST_INVALID;
                     state_in  = S_PUT;
                  end else if (!present_ff) begin
                     status_in = ST_MANUAL;
                     state_in  = S_PUT;
                  end else if (fs_ff == 16'd0) begin
                     status_in = ST_RANGE;
                     state_in  = S_PUT;
                  end else begin
                     md_cmd.start   = 1'b1;
                     md_cmd.mcand   = req_target_mv;
                     md_cmd.mplier  = {5'd0, fs_ff};
                     md_cmd.div_ppm = 1'b0;
                     state_in       = S_CODE;
                  end
               end else if (gain_ok) begin
                  md_cmd.start   = 1'b1;
                  md_cmd.mcand   = req_raw_mv;
                  md_cmd.mplier  = gain_ff;
                  md_cmd.div_ppm = 1'b1;
                  state_in       = S_CAL;
               end else begin
                  meas_in  = req_raw_mv;
                  state_in = S_EVAL;
               end
            end
         end
         S_CODE: begin
            if (md_rsp.done) begin
               code_in      = md_rsp.quotient[15:0];
               elapsed_in   = 16'd0;
               goal_in      = tgt_ff[14:0];
               allowed_in   = tol_ff;
               budget_in    = tmo_ff;
               adjusting_in = 1'b1;
               enabled_in   = 1'b1;
               status_in    = ST_ADJUSTING;
               state_in     = S_PUT;
            end
         end
         S_CAL: begin
            if (md_rsp.done) begin
               priority if (cal_sum[17] || cal_sum == 18'd0) begin
                  meas_in = 16'd0;
               end else if (cal_sum >= 18'd65535) begin
                  meas_in = 16'hFFFF;
               end else begin
                  meas_in = cal_sum[15:0];
               end
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!adjusting_ff) begin
               status_in = ST_IGNORED;
               state_in  = S_PUT;
            end else begin
               elapsed_in = el_sum[16] ? 16'hFFFF : el_sum[15:0];
               priority if (meas_ff > VOLT_MAX) begin
                  code_in      = 16'd0;
                  enabled_in   = 1'b0;
                  adjusting_in = 1'b0;
                  status_in    = ST_RANGE;
                  state_in     = S_PUT;
               end else if (err_abs[15:0] <= allowed_ff) begin
                  adjusting_in = 1'b0;
                  status_in    = ST_REACHED;
                  state_in     = S_PUT;
               end else begin
                  // The step is the error magnitude scaled by full scale over
                  // the voltage range; its sign is applied afterward.
                  neg_in         = err[16];
                  md_cmd.start   = 1'b1;
                  md_cmd.mcand   = err_abs[15:0];
                  md_cmd.mplier  = {5'd0, fs_ff};
                  md_cmd.div_ppm = 1'b0;
                  state_in       = S_STEP;
               end
            end
         end
         S_STEP: begin
            if (md_rsp.done) begin
               priority if (next_bad) begin
                  code_in      = 16'd0;
                  enabled_in   = 1'b0;
                  adjusting_in = 1'b0;
                  status_in    = ST_RANGE;
               end else if (elapsed_ff <= budget_ff) begin
                  code_in   = next_sum[15:0];
                  status_in = ST_ADJUSTING;
               end else begin
                  code_in      = 16'd0;
                  enabled_in   = 1'b0;
                  adjusting_in = 1'b0;
                  status_in    = ST_TIMEOUT;
               end
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = enabled_ff ? code_ff : 16'd0;
               rsp_en_in     = enabled_ff;
               rsp_status_in = status_ff;
               rsp_meas_in   = meas_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         offset_ff    <= 16'd0;
         calv_ff      <= 1'b0;
         present_ff   <= 1'b0;
         fs_ff        <= 16'd0;
         code_ff      <= 16'd0;
         elapsed_ff   <= 16'd0;
         goal_ff      <= 15'd0;
         allowed_ff   <= 16'd0;
         budget_ff    <= 16'd0;
         adjusting_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         calv_ff      <= calv_in;
         present_ff   <= present_in;
         fs_ff        <= fs_in;
         code_ff      <= code_in;
         elapsed_ff   <= elapsed_in;
         goal_ff      <= goal_in;
         allowed_ff   <= allowed_in;
         budget_ff    <= budget_in;
         adjusting_ff <= adjusting_in;
         enabled_ff   <= enabled_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tgt_ff        <= tgt_in;
      tol_ff        <= tol_in;
      tmo_ff        <= tmo_in;
      meas_ff       <= meas_in;
      neg_ff        <= neg_in;
      status_ff     <= status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_en_ff     <= rsp_en_in;
      rsp_status_ff <= rsp_status_in;
      rsp_meas_ff   <= rsp_meas_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dac_code     = rsp_code_ff;
   assign rsp_drive_enable = rsp_en_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_measured_mv  = rsp_meas_ff;

`ifndef ASSERT_OFF
   a_adjust_needs_drive: assert property (@(posedge clock) disable iff (reset)
      adjusting_ff |-> enabled_ff)
      else $error("adjustment active while drive is off");

   a_unit_idle_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_PUT) |-> !md_rsp.busy)
      else $error("arithmetic unit busy with no request waiting on it");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == S_CODE || state_ff == S_CAL || state_ff == S_STEP))
      else $error("arithmetic result arrived with nobody waiting");

   a_disabled_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_enable) |-> (rsp_dac_code == 16'd0))
      else $error("nonzero code reported with drive disabled");

   a_adjusting_has_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ADJUSTING) |-> rsp_drive_enable)
      else $error("adjusting status reported with drive disabled");
`endif

endmodule

`default_nettype wire
